@@ rtl/core/round_robin_tick_scheduler_top_defines.svh @@
// assertion helpers for the scheduler
`ifndef ROUND_ROBIN_TICK_SCHEDULER_TOP_DEFINES_SVH
`define ROUND_ROBIN_TICK_SCHEDULER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define RRTS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler check failed");
`define RRTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler check failed");
`else
`define RRTS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define RRTS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/core/rrts_pkg.sv @@
`default_nettype none
package rrts_pkg;

  localparam int unsigned QUEUE_DEPTH = 32;
  localparam int unsigned SLOT_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned COUNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned ID_W      = 8;
  localparam int unsigned BURST_W   = 16;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned SUM_W     = 48;
  localparam int unsigned QUANTUM_W = 8;

  localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 8'd10;
  localparam logic [ID_W-1:0]      ID_FIRST      = 8'd1;
  localparam logic [ID_W-1:0]      ID_LAST       = 8'd255;

  localparam int unsigned IN_TDATA_W   = 16;
  localparam int unsigned OUT_FIELDS_W = ID_W + TIME_W + 2 + 2 * TIME_W + 2 * SUM_W;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  localparam logic FUNC_ADMIT = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  typedef enum logic [1:0] {
    ST_ADMIT = 2'd0,
    ST_RAN   = 2'd1,
    ST_IDLE  = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [BURST_W-1:0] remaining;
    logic [TIME_W-1:0]  arrival;
    logic [BURST_W-1:0] burst;
  } slot_t;

  typedef struct packed {
    logic load_in;
    logic pick;
    logic run;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic run_needed;
  } stat_t;

endpackage
`default_nettype wire

@@ rtl/core/rrts_ctrl.sv @@
`default_nettype none
module rrts_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire rrts_pkg::stat_t stat_i,
  output rrts_pkg::cmd_t     cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PICK,
    S_RUN,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   load_out;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign load_out    = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o         = '0;
    cmd_o.load_in = accept;
    cmd_o.pick    = (state_q == S_PICK);
    cmd_o.run     = (state_q == S_RUN) && stat_i.run_needed;
    cmd_o.finish  = load_out;
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_PICK;
        end
      end
      S_PICK: state_d = S_RUN;
      S_RUN:  state_d = S_DONE;
      S_DONE: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/rrts_dp.sv @@
`default_nettype none
module rrts_dp (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire rrts_pkg::cmd_t                       cmd_i,
  output rrts_pkg::stat_t                           stat_o,
  input  wire logic                                 cfg_we_i,
  input  wire logic [rrts_pkg::QUANTUM_W-1:0]       cfg_data_i,
  input  wire logic                                 in_func_i,
  input  wire logic [rrts_pkg::BURST_W-1:0]         in_burst_i,
  output logic [rrts_pkg::OUT_TDATA_W-1:0]          out_tdata_o,
  output logic [1:0]                                out_tuser_o
);

  localparam int unsigned SLOT_W  = rrts_pkg::SLOT_W;
  localparam int unsigned COUNT_W = rrts_pkg::COUNT_W;
  localparam int unsigned DEPTH   = rrts_pkg::QUEUE_DEPTH;
  localparam int unsigned TIME_W  = rrts_pkg::TIME_W;
  localparam int unsigned SUM_W   = rrts_pkg::SUM_W;
  localparam int unsigned ID_W    = rrts_pkg::ID_W;
  localparam int unsigned QW      = rrts_pkg::QUANTUM_W;

  rrts_pkg::slot_t slot_q [DEPTH];

  logic                         func_q;
  logic [rrts_pkg::BURST_W-1:0] burst_q;
  logic [QW-1:0]                quantum_q;
  logic [COUNT_W-1:0]           count_q;
  logic [SLOT_W-1:0]            cur_q;
  logic [QW-1:0]                used_q;
  logic [TIME_W-1:0]            time_q;
  logic [ID_W-1:0]              next_id_q;
  logic [SUM_W-1:0]             wsum_q, tsum_q;
  rrts_pkg::status_e            status_q;
  logic [ID_W-1:0]              id_q;
  logic                         slice_q, fin_q;
  logic [TIME_W-1:0]            ta_q, wt_q;

  logic [rrts_pkg::OUT_TDATA_W-1:0] out_tdata_q;
  logic [1:0]                       out_tuser_q;

  logic                 admit_ok;
  logic [COUNT_W-1:0]   nx;
  logic [SLOT_W-1:0]    rot;
  logic [SLOT_W-1:0]    cur_pick;
  rrts_pkg::slot_t      sel;
  logic                 done;
  logic [QW:0]          lim, used_inc;
  logic [SUM_W:0]       wsum_add, tsum_add;
  logic [SUM_W-1:0]     wsum_d, tsum_d;

  assign stat_o.run_needed = (status_q == rrts_pkg::ST_RAN);

  assign admit_ok = (count_q < COUNT_W'(DEPTH));
  assign nx       = COUNT_W'(cur_q) + COUNT_W'(1);

  always_comb begin
    rot = (nx >= count_q) ? '0 : nx[SLOT_W-1:0];
    cur_pick = (used_q == '0) ? rot : cur_q;
    if (COUNT_W'(cur_pick) >= count_q) begin
      cur_pick = '0;
    end
  end

  assign sel      = slot_q[cur_q];
  assign done     = (sel.remaining <= rrts_pkg::BURST_W'(1));
  assign lim      = (quantum_q == '0) ? (QW+1)'(1 << QW) : {1'b0, quantum_q};
  assign used_inc = {1'b0, used_q} + (QW+1)'(1);

  assign wsum_add = {1'b0, wsum_q} + (SUM_W+1)'(wt_q);
  assign tsum_add = {1'b0, tsum_q} + (SUM_W+1)'(ta_q);
  always_comb begin
    wsum_d = wsum_q;
    tsum_d = tsum_q;
    if (fin_q) begin
      wsum_d = wsum_add[SUM_W] ? {SUM_W{1'b1}} : wsum_add[SUM_W-1:0];
      tsum_d = tsum_add[SUM_W] ? {SUM_W{1'b1}} : tsum_add[SUM_W-1:0];
    end
  end

  // queue storage with parallel compaction
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (cmd_i.pick && func_q == rrts_pkg::FUNC_ADMIT && admit_ok
          && count_q == COUNT_W'(i)) begin
        slot_q[i].id        <= next_id_q;
        slot_q[i].remaining <= burst_q;
        slot_q[i].arrival   <= time_q;
        slot_q[i].burst     <= burst_q;
      end else if (cmd_i.run && done) begin
        if (i + 1 < DEPTH) begin
          if (SLOT_W'(i) >= cur_q && COUNT_W'(i + 1) < count_q) begin
            slot_q[i] <= slot_q[(i + 1) % DEPTH];
          end
        end
      end else if (cmd_i.run && cur_q == SLOT_W'(i)) begin
        slot_q[i].remaining <= sel.remaining - rrts_pkg::BURST_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      func_q  <= in_func_i;
      burst_q <= in_burst_i;
    end
    if (cmd_i.pick) begin
      id_q    <= (func_q == rrts_pkg::FUNC_ADMIT && admit_ok) ? next_id_q : '0;
      slice_q <= (func_q == rrts_pkg::FUNC_TICK && count_q != '0) ? (used_q == '0) : 1'b0;
      fin_q   <= 1'b0;
      ta_q    <= '0;
      wt_q    <= '0;
    end
    if (cmd_i.run) begin
      id_q <= sel.id;
      if (done) begin
        fin_q <= 1'b1;
        ta_q  <= time_q - sel.arrival;
        wt_q  <= time_q - sel.arrival - TIME_W'(sel.burst);
      end
    end
    if (cmd_i.finish) begin
      out_tuser_q <= status_q;
      out_tdata_q <= {{rrts_pkg::OUT_PAD_W{1'b0}}, tsum_d, wsum_d, wt_q, ta_q,
                      fin_q, slice_q, time_q, id_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q <= rrts_pkg::QUANTUM_RESET;
      count_q   <= '0;
      cur_q     <= SLOT_W'(DEPTH - 1);
      used_q    <= '0;
      time_q    <= '0;
      next_id_q <= rrts_pkg::ID_FIRST;
      wsum_q    <= '0;
      tsum_q    <= '0;
      status_q  <= rrts_pkg::ST_IDLE;
    end else begin
      if (cfg_we_i) begin
        quantum_q <= cfg_data_i;
      end
      if (cmd_i.pick) begin
        if (func_q == rrts_pkg::FUNC_ADMIT) begin
          if (admit_ok) begin
            status_q  <= rrts_pkg::ST_ADMIT;
            count_q   <= count_q + COUNT_W'(1);
            next_id_q <= (next_id_q == rrts_pkg::ID_LAST) ? rrts_pkg::ID_FIRST
                                                          : next_id_q + ID_W'(1);
          end else begin
            status_q <= rrts_pkg::ST_FULL;
          end
        end else begin
          time_q <= time_q + TIME_W'(1);
          if (count_q == '0) begin
            status_q <= rrts_pkg::ST_IDLE;
          end else begin
            status_q <= rrts_pkg::ST_RAN;
            cur_q    <= cur_pick;
          end
        end
      end
      if (cmd_i.run) begin
        if (done) begin
          count_q <= count_q - COUNT_W'(1);
          used_q  <= '0;
          cur_q   <= (cur_q == '0) ? SLOT_W'(DEPTH - 1) : cur_q - SLOT_W'(1);
        end else begin
          used_q <= (used_inc >= lim) ? '0 : used_inc[QW-1:0];
        end
      end
      if (cmd_i.finish) begin
        wsum_q <= wsum_d;
        tsum_q <= tsum_d;
      end
    end
  end

  assign out_tdata_o = out_tdata_q;
  assign out_tuser_o = out_tuser_q;

endmodule
`default_nettype wire

@@ rtl/core/round_robin_tick_scheduler_top.sv @@
// Round-robin tick scheduler. A word with tuser 0 admits a job whose burst time is in
// tdata; a word with tuser 1 is one clock tick that runs the current job for one unit and
// rotates jobs at each quantum boundary. Every input word yields exactly one result word.
// An accepted word is worked in three steps (pick, run, accumulate) and the block
// accepts again the cycle after its result is loaded. The result sits in an output
// register, so the next item is accepted while it waits; the accumulate step of that item
// then holds until the register frees. The controller sequences each item around the
// single queue read and the 48-bit saturating sum adders. The user must write the
// quantum register through the cfg port only while the block is idle; the block itself
// does not enforce it.
`default_nettype none
`include "round_robin_tick_scheduler_top_defines.svh"
module round_robin_tick_scheduler_top (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [rrts_pkg::QUANTUM_W-1:0]       cfg_data_i,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  input  wire logic [rrts_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // burst
  input  wire logic                                 s_axis_tuser,  // func
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // job_id, time_value, slice_start, finished, turnaround, waiting,
  // waiting_sum, turnaround_sum, zero pad
  output logic [rrts_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
  output logic [1:0]                                m_axis_tuser   // status
);

  rrts_pkg::cmd_t  cmd;
  rrts_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  rrts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rrts_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_func_i   (s_axis_tuser),
    .in_burst_i  (s_axis_tdata[rrts_pkg::BURST_W-1:0]),
    .out_tdata_o (m_axis_tdata),
    .out_tuser_o (m_axis_tuser)
  );

  `RRTS_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `RRTS_ASSERT_SAME(a_run_only_on_cmd, clk_i, rst_ni, cmd.run, stat.run_needed && !cmd.pick)
  `RRTS_ASSERT_SAME(a_full_no_id, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser == rrts_pkg::ST_FULL, m_axis_tdata[7:0] == 8'd0)
  `RRTS_ASSERT_SAME(a_finish_only_ran, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[41], m_axis_tuser == rrts_pkg::ST_RAN)

endmodule
`default_nettype wire
